// ===== design/nrtw_pkg.sv =====
// ----------------------------------------------------------------------------
// nrtw_pkg
// Types and constants shared by the record text extractor.
// ----------------------------------------------------------------------------
package nrtw_pkg;

  // Flag bits in the record header byte
  localparam int unsigned FlagShortBit = 4;
  localparam int unsigned FlagIdBit    = 3;

  // Printable range and newline code
  localparam logic [7:0] PrintLo  = 8'd33;
  localparam logic [7:0] PrintHi  = 8'd126;
  localparam logic [6:0] CharNl   = 7'd10;

  // Register reset values and indexes
  localparam logic [7:0] LineWidthRst = 8'd25;
  localparam logic [7:0] LineCountRst = 8'd8;
  localparam logic       RegLineWidth = 1'b0;
  localparam logic       RegLineCount = 1'b1;

  // Result kinds
  localparam logic KindText = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // Output queue depth (one byte yields at most three results)
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned MaxRes = 3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPELEN,
    PH_PLEN,
    PH_IDLEN,
    PH_SKIP,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic        kind;
    logic [6:0]  text_char;
    logic [31:0] payload_length;
    logic        truncated;
    logic        last;
  } result_t;

endpackage

// ===== design/ndef_record_text_wrapper.sv =====
// ----------------------------------------------------------------------------
// ndef_record_text_wrapper
// Parses an NDEF record header and turns printable payload bytes into text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one record byte per transfer,
//   first_byte_i marks the header flags byte. Output channel
//   (out_valid_o/out_ready_i) carries text characters, inserted newlines and
//   at most one end result per record, with last_o on the final result of
//   each byte. A transfer is registered in the input register, then decoded
//   into a 4-entry result queue once the queue has room; its first result is
//   then offered on the output. One byte per cycle is taken while the
//   receiver keeps up; a byte that makes three results hands them out in turn,
//   and the input stalls once the queue cannot take three more results.
//   When the receiver stalls, results wait in the queue and the input stalls.
//   Each write on the configuration port starts a remainder pass (one text
//   position bit per cycle) that rebuilds the line column; the input is not
//   ready during the pass. After reset: line width 25, 8 lines, parser idle,
//   queue empty.
// ----------------------------------------------------------------------------
module ndef_record_text_wrapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [6:0]  text_char_o,
  output logic [31:0] payload_length_o,
  output logic        truncated_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import nrtw_pkg::*;

  // Configuration and derived values
  logic [7:0]  lw_q, lc_q;
  logic [8:0]  div9;
  logic [16:0] cap_prod;
  logic [15:0] cap_q;

  // Remainder pass
  logic        busy_q;
  logic [3:0]  bit_q;
  logic [8:0]  rem_q;
  logic [9:0]  rem_sh;
  logic [8:0]  rem_nx;

  // Input register
  logic        in_valid_q;
  logic [7:0]  in_data_q;
  logic        in_first_q;
  logic        fire;

  // Parser state
  phase_e      phase_q, phase_d;
  logic        short_q, short_d;
  logic        idp_q, idp_d;
  logic [1:0]  lbl_q, lbl_d;
  logic [8:0]  skip_q, skip_d;
  logic [7:0]  tlen_q, tlen_d;
  logic [31:0] dlen_q, dlen_d;
  logic [31:0] pleft_q, pleft_d;
  logic [15:0] tpos_q, tpos_d;
  logic [8:0]  col_q, col_d;

  // Decode results
  result_t     res [MaxRes];
  logic [1:0]  nres;
  logic        ended;
  logic        printable;
  logic [31:0] dlen_new;
  logic [8:0]  skip_new;

  // Result queue
  result_t          q_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             pop;

  assign div9     = {1'b0, lw_q} + 9'd1;
  assign cap_prod = {9'd0, lc_q} * {8'd0, div9};

  // One restoring step of tpos mod (line_width + 1)
  assign rem_sh = {rem_q, tpos_q[bit_q]};
  assign rem_nx = (rem_sh >= {1'b0, div9}) ? 9'(rem_sh - {1'b0, div9}) : rem_sh[8:0];

  assign fire       = in_valid_q && (cnt_q <= (QPtrW+1)'(QDepth - MaxRes));
  assign in_ready_o = !busy_q && (!in_valid_q || fire);
  assign pop        = out_valid_o && out_ready_i;
  assign printable  = (in_data_q >= PrintLo) && (in_data_q <= PrintHi);

  // Decode one byte: next state and up to three results
  always_comb begin
    phase_d  = phase_q;
    short_d  = short_q;
    idp_d    = idp_q;
    lbl_d    = lbl_q;
    skip_d   = skip_q;
    tlen_d   = tlen_q;
    dlen_d   = dlen_q;
    pleft_d  = pleft_q;
    tpos_d   = tpos_q;
    col_d    = col_q;
    nres     = 2'd0;
    ended    = 1'b0;
    dlen_new = {dlen_q[23:0], in_data_q};
    skip_new = 9'd0;
    for (int k = 0; k < MaxRes; k++) begin
      res[k] = '0;
    end
    if (in_first_q) begin
      short_d = in_data_q[FlagShortBit];
      idp_d   = in_data_q[FlagIdBit];
      dlen_d  = '0;
      pleft_d = '0;
      skip_d  = '0;
      lbl_d   = '0;
      tpos_d  = '0;
      col_d   = '0;
      phase_d = PH_TYPELEN;
    end else begin
      unique case (phase_q)
        PH_TYPELEN: begin
          tlen_d  = in_data_q;
          lbl_d   = short_q ? 2'd0 : 2'd3;
          phase_d = PH_PLEN;
        end
        PH_PLEN: begin
          dlen_d = dlen_new;
          if (lbl_q != 2'd0) begin
            lbl_d = lbl_q - 2'd1;
          end else if (idp_q) begin
            phase_d = PH_IDLEN;
          end else begin
            skip_new = {1'b0, tlen_q};
            ended    = 1'b1;
          end
        end
        PH_IDLEN: begin
          skip_new = {1'b0, tlen_q} + {1'b0, in_data_q};
          ended    = 1'b1;
        end
        PH_SKIP: begin
          skip_d = skip_q - 9'd1;
          if (skip_d == 9'd0) begin
            pleft_d = dlen_q;
            if (dlen_q == 32'd0) begin
              res[0]  = '{kind: KindEnd, text_char: '0, payload_length: dlen_q,
                          truncated: 1'b0, last: 1'b0};
              nres    = 2'd1;
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          pleft_d = pleft_q - 32'd1;
          if (printable) begin
            // newline when this position closes a line and room remains
            if (tpos_q != 16'd0 && col_q == {1'b0, lw_q} &&
                ({1'b0, tpos_q} + 17'd1) < {1'b0, cap_q}) begin
              res[nres] = '{kind: KindText, text_char: CharNl, payload_length: '0,
                            truncated: 1'b0, last: 1'b0};
              nres   = nres + 2'd1;
              tpos_d = tpos_q + 16'd1;
              col_d  = '0;
            end
            if (({1'b0, tpos_d} + 17'd1) >= {1'b0, cap_q}) begin
              res[nres] = '{kind: KindEnd, text_char: '0, payload_length: dlen_q,
                            truncated: 1'b1, last: 1'b0};
              nres    = nres + 2'd1;
              phase_d = PH_DONE;
            end else begin
              res[nres] = '{kind: KindText, text_char: in_data_q[6:0],
                            payload_length: '0, truncated: 1'b0, last: 1'b0};
              nres   = nres + 2'd1;
              tpos_d = tpos_d + 16'd1;
              col_d  = (col_d == {1'b0, lw_q}) ? 9'd0 : col_d + 9'd1;
            end
          end
          if (phase_d != PH_DONE && pleft_d == 32'd0) begin
            res[nres] = '{kind: KindEnd, text_char: '0, payload_length: dlen_q,
                          truncated: 1'b0, last: 1'b0};
            nres    = nres + 2'd1;
            phase_d = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      // end of header: skip type/ID bytes, go to payload, or end an empty record
      if (ended) begin
        skip_d = skip_new;
        if (skip_new != 9'd0) begin
          phase_d = PH_SKIP;
        end else begin
          pleft_d = dlen_d;
          if (dlen_d == 32'd0) begin
            res[0]  = '{kind: KindEnd, text_char: '0, payload_length: dlen_d,
                        truncated: 1'b0, last: 1'b0};
            nres    = 2'd1;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
    end
    if (nres != 2'd0) begin
      res[nres - 2'd1].last = 1'b1;
    end
  end

  // Configuration, capacity and remainder pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q   <= LineWidthRst;
      lc_q   <= LineCountRst;
      cap_q  <= 16'd208;
      busy_q <= 1'b0;
      bit_q  <= '0;
      rem_q  <= '0;
    end else begin
      cap_q <= cap_prod[15:0];
      if (cfg_we_i) begin
        if (cfg_index_i == RegLineWidth) begin
          lw_q <= cfg_data_i;
        end else begin
          lc_q <= cfg_data_i;
        end
        busy_q <= 1'b1;
        bit_q  <= 4'd15;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_nx;
        bit_q <= bit_q - 4'd1;
        if (bit_q == 4'd0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q  <= data_byte_i;
      in_first_q <= first_byte_i;
    end
  end

  // Parser state; the column also takes the remainder pass result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      short_q <= 1'b0;
      idp_q   <= 1'b0;
      lbl_q   <= '0;
      skip_q  <= '0;
      tlen_q  <= '0;
      dlen_q  <= '0;
      pleft_q <= '0;
      tpos_q  <= '0;
      col_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      short_q <= short_d;
      idp_q   <= idp_d;
      lbl_q   <= lbl_d;
      skip_q  <= skip_d;
      tlen_q  <= tlen_d;
      dlen_q  <= dlen_d;
      pleft_q <= pleft_d;
      tpos_q  <= tpos_d;
      col_q   <= col_d;
    end else if (busy_q && !cfg_we_i && bit_q == 4'd0) begin
      col_q <= rem_nx;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (fire) begin
        wr_q <= wr_q + QPtrW'(nres);
      end
      if (pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + (fire ? (QPtrW+1)'(nres) : '0) - (QPtrW+1)'(pop);
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int k = 0; k < MaxRes; k++) begin
        if (2'(k) < nres) begin
          q_q[wr_q + QPtrW'(k)] <= res[k];
        end
      end
    end
  end

  assign out_valid_o      = (cnt_q != '0);
  assign kind_o           = q_q[rd_q].kind;
  assign text_char_o      = q_q[rd_q].text_char;
  assign payload_length_o = q_q[rd_q].payload_length;
  assign truncated_o      = q_q[rd_q].truncated;
  assign last_o           = q_q[rd_q].last;

endmodule

// ===== test/tb_ndef_record_text_wrapper.sv =====
// ----------------------------------------------------------------------------
// tb_ndef_record_text_wrapper
// Drives record bytes into the NDEF text extractor and checks every text
// character, inserted newline and end-of-record result against an in-bench
// model of the header parser and the line/capacity logic. A short table of
// directed bytes comes first, then randomized records under several line
// settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_ndef_record_text_wrapper;
  import nrtw_pkg::*;

  localparam int SettleCycles = 10;
  localparam int HoldCycles   = 100;
  localparam int IdlePct      = 21;

  // Directed table rows: predicted, typed "no result", typed end, register write
  typedef enum logic [1:0] {ROW_BYTE, ROW_NONE, ROW_END, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   how;
    logic [7:0]  data;    // byte, or line width on a register row
    logic        first;
    logic [31:0] len;     // typed end: payload length
    logic        trunc;   // typed end: truncated flag
    logic [7:0]  lines;   // register row: line count
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        first_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [6:0]  text_char_o;
  logic [31:0] payload_length_o;
  logic        truncated_o;
  logic        last_o;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [7:0]  cfg_data_i  = 8'h00;

  ndef_record_text_wrapper dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .text_char_o      (text_char_o),
    .payload_length_o (payload_length_o),
    .truncated_o      (truncated_o),
    .last_o           (last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Expected results in arrival order, and the results of the byte just taken
  result_t   due_results[$];
  result_t   byte_results[$];
  dir_row_t  dir_tbl[$];

  int mismatches   = 0;
  int results_seen = 0;
  int bytes_used   = 0;   // bytes the parser actually acted on
  bit calm         = 1'b0;
  int hold_asks    = 0;

  // Model state and line settings
  phase_e      ph        = PH_IDLE;
  logic        short_rec = 1'b0;
  logic        id_pres   = 1'b0;
  logic [1:0]  len_left  = '0;
  logic [8:0]  skip_cnt  = '0;
  logic [7:0]  rec_tlen  = '0;
  logic [31:0] dec_len   = '0;
  logic [31:0] pay_left  = '0;
  logic [15:0] text_pos  = '0;
  logic [7:0]  line_w    = LineWidthRst;
  logic [7:0]  line_cnt  = LineCountRst;

  // --------------------------------------------------------------------------
  // Model of the extractor
  // --------------------------------------------------------------------------
  function automatic void emit(logic k, logic [6:0] ch, logic [31:0] len, logic tr);
    byte_results.push_back(result_t'{k, ch, len, tr, 1'b0});
  endfunction

  function automatic void close_record(logic tr);
    ph = PH_DONE;
    emit(KindEnd, 7'd0, dec_len, tr);
  endfunction

  // empty payload closes the record on the spot
  function automatic void open_payload();
    pay_left = dec_len;
    if (pay_left == 0) close_record(1'b0);
    else ph = PH_PAYLOAD;
  endfunction

  function automatic void after_header();
    if (skip_cnt != 0) ph = PH_SKIP;
    else open_payload();
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic f);
    int unsigned span;
    int unsigned cap;
    byte_results.delete();
    if (f) begin
      // a flags byte restarts parsing in any phase
      short_rec = b[FlagShortBit];
      id_pres   = b[FlagIdBit];
      dec_len   = '0;
      pay_left  = '0;
      skip_cnt  = '0;
      len_left  = '0;
      text_pos  = '0;
      ph        = PH_TYPELEN;
    end else begin
      case (ph)
        PH_TYPELEN: begin
          rec_tlen = b;
          len_left = short_rec ? 2'd0 : 2'd3;
          ph       = PH_PLEN;
        end
        PH_PLEN: begin
          dec_len = {dec_len[23:0], b};
          if (len_left != 0) len_left--;
          else if (id_pres) ph = PH_IDLEN;
          else begin
            skip_cnt = {1'b0, rec_tlen};
            after_header();
          end
        end
        PH_IDLEN: begin
          skip_cnt = {1'b0, rec_tlen} + {1'b0, b};
          after_header();
        end
        PH_SKIP: begin
          skip_cnt--;
          if (skip_cnt == 0) open_payload();
        end
        PH_PAYLOAD: begin
          span = 32'(line_w) + 32'd1;
          cap  = 32'(line_cnt) * span;
          pay_left--;
          if (b >= PrintLo && b <= PrintHi) begin
            // newline ahead of a character that opens a new line, room allowing
            if (text_pos != 0 && (32'(text_pos) + 1) % span == 0 &&
                32'(text_pos) + 1 < cap) begin
              emit(KindText, CharNl, 32'd0, 1'b0);
              text_pos++;
            end
            if (32'(text_pos) + 1 >= cap) close_record(1'b1);
            else begin
              emit(KindText, b[6:0], 32'd0, 1'b0);
              text_pos++;
            end
          end
          if (ph == PH_PAYLOAD && pay_left == 0) close_record(1'b0);
        end
        default: ;
      endcase
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      report("result with nothing pending", {25'd0, text_char_o}, 32'd0);
    end else begin
      want = due_results.pop_front();
      if (kind_o !== want.kind) report("kind", 32'(kind_o), 32'(want.kind));
      if (text_char_o !== want.text_char)
        report("text_char", 32'(text_char_o), 32'(want.text_char));
      if (payload_length_o !== want.payload_length)
        report("payload_length", payload_length_o, want.payload_length);
      if (truncated_o !== want.truncated)
        report("truncated", 32'(truncated_o), 32'(want.truncated));
      if (last_o !== want.last) report("last", 32'(last_o), 32'(want.last));
    end
  endtask

  // Receiver: random backpressure, plus a long hold-off when asked
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_result();
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99, 0) >= IdlePct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] d, input logic f,
                           input row_kind_e how = ROW_BYTE,
                           input logic [31:0] len = '0, input logic trunc = 1'b0);
    in_valid_i   <= 1'b1;
    data_byte_i  <= d;
    first_byte_i <= f;
    do @(posedge clk_i); while (!in_ready_o);
    // transfer taken at this edge
    if (f || (ph != PH_IDLE && ph != PH_DONE)) bytes_used++;
    predict_byte(d, f);
    case (how)
      ROW_NONE: ;
      ROW_END:  due_results.push_back(result_t'{KindEnd, 7'd0, len, trunc, 1'b1});
      default:  foreach (byte_results[i]) due_results.push_back(byte_results[i]);
    endcase
  endtask

  task automatic sender_idle();
    if (!calm && $urandom_range(99, 0) < IdlePct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every pending result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [7:0] lw, logic [7:0] lc);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegLineWidth;
    cfg_data_i  <= lw;
    @(posedge clk_i);
    cfg_index_i <= RegLineCount;
    cfg_data_i  <= lc;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    line_w   = lw;
    line_cnt = lc;
  endtask

  // One record with random content; some are cut short by the next record
  task automatic random_record();
    logic [7:0]  rec[$];
    logic [7:0]  flags;
    logic [31:0] big_len;
    int tl;
    int plen;
    int idl;
    int cut;
    flags = 8'($urandom_range(255, 0));
    tl    = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 3) : $urandom_range(2, 0);
    plen  = $urandom_range(14, 0);
    idl   = $urandom_range(2, 0);
    cut   = ($urandom_range(99, 0) < 12) ? $urandom_range(6, 1) : 1000;
    // noise between records
    if ($urandom_range(9, 0) == 0) begin
      send_byte(8'($urandom_range(255, 0)), 1'b0);
      sender_idle();
    end
    rec.push_back(flags);
    rec.push_back(8'(tl));
    if (flags[FlagShortBit]) begin
      rec.push_back(8'(plen));
    end else begin
      // now and then a huge length that only a restart can end
      big_len = ($urandom_range(19, 0) == 0) ? $urandom() : 32'(plen);
      for (int i = 3; i >= 0; i--) rec.push_back(big_len[8*i +: 8]);
    end
    if (flags[FlagIdBit]) rec.push_back(8'(idl));
    else idl = 0;
    repeat (tl + idl) rec.push_back(8'($urandom_range(255, 0)));
    repeat (plen) begin
      if ($urandom_range(99, 0) < 70) rec.push_back(8'($urandom_range(126, 33)));
      else rec.push_back(8'($urandom_range(255, 0)));
    end
    foreach (rec[i]) begin
      if (i < cut) begin
        send_byte(rec[i], i == 0);
        sender_idle();
      end
    end
  endtask

  task automatic run_phase(logic [7:0] lw, logic [7:0] lc, int target,
                           bit hold_rx, bit no_idle, bit mid_pause);
    int goal;
    bit paused;
    settle();
    write_regs(lw, lc);
    calm   = no_idle;
    paused = 1'b0;
    if (hold_rx) hold_asks++;
    goal = bytes_used + target;
    while (bytes_used < goal) begin
      random_record();
      if (mid_pause && !paused && bytes_used >= goal - target / 2) begin
        settle();
        paused = 1'b1;
      end
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // stray byte while idle
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'hFF, 1'b1 ^ 1'b1, 32'd0, 1'b0, 8'd0});
    // long record, no ID, all-zero length: end on the last length byte
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'h00, 1'b1, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'h00, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'h00, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'h00, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'h00, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_END,  8'h00, 1'b0, 32'd0, 1'b0, 8'd0});
    // short record with ID, one skipped byte, printable range edges
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'h18, 1'b1, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h01, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h04, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h00, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'hAA, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h21, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h7F, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h20, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h7E, 1'b0, 32'd0, 1'b0, 8'd0});
    // one character per line, two lines: capacity of four positions
    dir_tbl.push_back(dir_row_t'{ROW_CFG,  8'd1,  1'b0, 32'd0, 1'b0, 8'd2});
    // restart before the header is done
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'h10, 1'b1, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'h10, 1'b1, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h00, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h02, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h41, 1'b0, 32'd0, 1'b0, 8'd0});
    // newline, character and normal end on one byte at exactly full capacity
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h42, 1'b0, 32'd0, 1'b0, 8'd0});
    // capacity runs out before the payload does
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'h10, 1'b1, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h00, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h05, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h21, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_BYTE, 8'h7E, 1'b0, 32'd0, 1'b0, 8'd0});
    dir_tbl.push_back(dir_row_t'{ROW_END,  8'h78, 1'b0, 32'd5, 1'b1, 8'd0});
    // leftover payload after truncation is ignored
    dir_tbl.push_back(dir_row_t'{ROW_NONE, 8'h79, 1'b0, 32'd0, 1'b0, 8'd0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].how == ROW_CFG) begin
        settle();
        write_regs(dir_tbl[i].data, dir_tbl[i].lines);
      end else begin
        send_byte(dir_tbl[i].data, dir_tbl[i].first, dir_tbl[i].how,
                  dir_tbl[i].len, dir_tbl[i].trunc);
        sender_idle();
      end
    end

    // random part: width and count of one, largest with a long receiver hold-off,
    // a stretch without idling, then random small settings with a full drain
    run_phase(8'd1, 8'd1, 25, 1'b0, 1'b0, 1'b0);
    run_phase(8'd255, 8'd255, 22, 1'b1, 1'b0, 1'b0);
    run_phase(8'd3, 8'd2, 25, 1'b0, 1'b1, 1'b0);
    run_phase(8'($urandom_range(8, 1)), 8'($urandom_range(4, 1)), 28, 1'b0, 1'b0, 1'b1);

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
